// ----- sv/hlbc_pkg.sv -----
`default_nettype none
package hlbc_pkg;

  typedef enum logic [1:0] {
    KIND_GET     = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_PIN     = 2'd2,
    KIND_UNPIN   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  localparam int KEY_W = 32;
  localparam int TIME_W = 32;
  localparam int DEV_W = 8;
  localparam int SLOT_W = 5;
  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam int HASH_MUL_SHIFT = 5;  // dev * 31 = (dev << 5) - dev
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic load;      // capture the input transaction
    logic hash;      // one step of the bucket remainder
    logic scan;      // issue one entry read of the scan
    logic rmw_read;  // read the addressed slot for release, pin or unpin
    logic commit;    // update state and load the result register
  } cmd_t;

  typedef struct packed {
    logic in_get;
    logic hash_done;
    logic scan_done;
    logic out_free;
  } sts_t;

  function automatic logic [COUNT_W-1:0] count_inc(logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 8'd1;
  endfunction

endpackage
`default_nettype wire

// ----- sv/hashed_lru_block_buffer_cache_unit.sv -----
`default_nettype none
// Block-buffer tag store with hashed LRU replacement over ENTRIES slots.
// Input channel s_*: one transaction per request. s_tuser carries the kind
// (get, release, pin, unpin); s_tdata carries dev, block number, slot and the
// current tick. Output channel m_*: exactly one result transaction per request,
// carrying the granted slot, the need-read flag and a status code.
// A get first reduces its hash to the home bucket, four key bits per cycle,
// then makes one pass over all entries through the tag and count/time
// memories, one entry per cycle. It commits once the result register is free
// and then returns to idle, where the next request can be accepted.
// Release, pin and unpin do one read-modify-write of the addressed slot and
// commit the same way, also waiting for the result register to be free.
// One request is in flight at a time; s_tready is high only while idle.
// The result sits in an output register, so the next request is accepted
// while a result waits; a stalled receiver only holds back the commit of the
// following request until the register is free.
// Reset clears the fill count, all reference counts and release times (by
// per-entry valid bits), and the result valid flag.
module hashed_lru_block_buffer_cache_unit #(
  parameter int ENTRIES = 32,
  parameter int BUCKETS = 13
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // dev [7:0], block_number [39:8], slot [44:40], now_tick [76:45], zeros
  input  wire logic [79:0] s_tdata,
  // kind [1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // granted_slot [4:0], need_read [5], status [7:6]
  output logic      [7:0]  m_tdata
);

  hlbc_pkg::cmd_t cmd;
  hlbc_pkg::sts_t sts;

  hlbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hlbc_dp #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// ----- sv/hlbc_ram.sv -----
`default_nettype none
module hlbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/hlbc_ctrl.sv -----
`default_nettype none
module hlbc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire hlbc_pkg::sts_t sts,
  output hlbc_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HASH = 6'b000010,
    S_SCAN = 6'b000100,
    S_TAIL = 6'b001000,
    S_READ = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = sts.in_get ? S_HASH : S_READ;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        if (sts.hash_done) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = S_TAIL;
      end
      // The last entry read is evaluated here.
      S_TAIL: state_next = S_FIN;
      S_READ: begin
        cmd.rmw_read = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/hlbc_dp.sv -----
`default_nettype none
module hlbc_dp #(
  parameter int ENTRIES = 32,
  parameter int BUCKETS = 13
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire hlbc_pkg::cmd_t                      cmd,
  output hlbc_pkg::sts_t                           sts,
  input  wire logic [hlbc_pkg::IN_DATA_W-1:0]      s_tdata,
  input  wire logic [1:0]                          s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [hlbc_pkg::OUT_DATA_W-1:0]     m_tdata
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int TAG_W = BW + hlbc_pkg::KEY_W + hlbc_pkg::DEV_W;
  localparam int LIFE_W = hlbc_pkg::TIME_W + hlbc_pkg::COUNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);
  localparam logic [BW:0] NBUCK = (BW + 1)'(BUCKETS);
  localparam int HASH_STEPS = hlbc_pkg::KEY_W / 4;

  // Remainder tables: FOLD_TAB[r] = (r * 16) mod BUCKETS, MOD_TAB[x] = x mod BUCKETS.
  typedef logic [63:0][5:0] fold_tab_t;
  typedef logic [79:0][5:0] mod_tab_t;

  function automatic fold_tab_t fold_init();
    fold_tab_t t;
    for (int i = 0; i < 64; i++) t[i] = 6'((i * 16) % BUCKETS);
    return t;
  endfunction

  function automatic mod_tab_t mod_init();
    mod_tab_t t;
    for (int i = 0; i < 80; i++) t[i] = 6'(i % BUCKETS);
    return t;
  endfunction

  localparam fold_tab_t FOLD_TAB = fold_init();
  localparam mod_tab_t MOD_TAB = mod_init();

  // Captured transaction.
  hlbc_pkg::kind_t kind;
  logic [hlbc_pkg::DEV_W-1:0] dev;
  logic [hlbc_pkg::KEY_W-1:0] blk;
  logic [hlbc_pkg::SLOT_W-1:0] slot;
  logic [hlbc_pkg::TIME_W-1:0] now_tick;

  // Bucket remainder, four key bits per cycle, most significant first.
  logic [hlbc_pkg::KEY_W-1:0] key;
  logic [BW-1:0] home;
  logic [2:0] hash_cnt;
  logic [3:0] digit;
  logic [6:0] rem_sum;
  logic [5:0] rem_next;

  logic [CW-1:0] fill_count;
  logic [AW-1:0] scan_cnt;
  logic [ENTRIES-1:0] life_vld;

  // Scan pipeline and the running choices.
  logic ev_valid;
  logic [AW-1:0] ev_idx;
  logic life_vld_q;
  logic hit;
  logic [AW-1:0] hit_idx;
  logic [LIFE_W-1:0] hit_life;
  logic found;
  logic [AW-1:0] pick_idx;
  logic [BW-1:0] pick_dist;
  logic [hlbc_pkg::TIME_W-1:0] pick_time;
  logic [hlbc_pkg::TIME_W-1:0] fill_time;

  logic out_valid;
  logic [hlbc_pkg::OUT_DATA_W-1:0] out_data;

  // RAM ports.
  logic tag_we, life_we, life_re;
  logic [AW-1:0] tag_waddr, life_waddr, life_raddr;
  logic [TAG_W-1:0] tag_wdata, tag_q;
  logic [LIFE_W-1:0] life_wdata, life_q, life_eff;

  logic [AW-1:0] slot_addr;
  logic slot_in_range;
  logic [BW-1:0] ev_bucket, ev_dist;
  logic [BW:0] dist_wide;
  logic [hlbc_pkg::COUNT_W-1:0] ev_ref;
  logic [hlbc_pkg::TIME_W-1:0] ev_time;
  logic ev_filled, ev_match, ev_better;

  logic [hlbc_pkg::SLOT_W-1:0] res_slot;
  logic res_need;
  hlbc_pkg::status_t res_status;
  logic [CW-1:0] fill_next;

  assign slot_addr = AW'(slot);
  assign slot_in_range = (32'(slot) < ENTRIES);

  assign sts.in_get = (hlbc_pkg::kind_t'(s_tuser) == hlbc_pkg::KIND_GET);
  assign sts.hash_done = (hash_cnt == 3'(HASH_STEPS - 1));
  assign sts.scan_done = (scan_cnt == LAST_ADDR);
  assign sts.out_free = !out_valid || m_tready;

  assign digit = key[hlbc_pkg::KEY_W-1 -: 4];
  assign rem_sum = {1'b0, FOLD_TAB[6'(home)]} + {3'b0, digit};
  assign rem_next = MOD_TAB[rem_sum];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= hlbc_pkg::kind_t'(s_tuser);
      dev <= s_tdata[7:0];
      blk <= s_tdata[39:8];
      slot <= s_tdata[44:40];
      now_tick <= s_tdata[76:45];
      key <= 32'({s_tdata[7:0], 5'b0}) - 32'(s_tdata[7:0]) + s_tdata[39:8];
      home <= '0;
      hash_cnt <= '0;
    end else if (cmd.hash) begin
      key <= {key[hlbc_pkg::KEY_W-5:0], 4'b0};
      home <= BW'(rem_next);
      hash_cnt <= hash_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_cnt <= '0;
    end else if (cmd.scan) begin
      scan_cnt <= scan_cnt + AW'(1);
    end
  end

  assign life_re = cmd.scan || cmd.rmw_read;
  assign life_raddr = cmd.scan ? scan_cnt : slot_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) ev_idx <= scan_cnt;
    if (life_re) life_vld_q <= life_vld[life_raddr];
  end

  // A slot never written reads as count zero, time zero.
  assign life_eff = life_vld_q ? life_q : '0;
  assign ev_ref = life_eff[hlbc_pkg::COUNT_W-1:0];
  assign ev_time = life_eff[LIFE_W-1:hlbc_pkg::COUNT_W];
  assign ev_bucket = tag_q[TAG_W-1:hlbc_pkg::KEY_W+hlbc_pkg::DEV_W];

  // Distance of the entry's bucket from home, going round the buckets.
  assign dist_wide = (ev_bucket >= home) ? {1'b0, ev_bucket} - {1'b0, home}
                                         : {1'b0, ev_bucket} + NBUCK - {1'b0, home};
  assign ev_dist = BW'(dist_wide);

  assign ev_filled = (CW'(ev_idx) < fill_count);
  assign ev_match = ev_filled && (tag_q[hlbc_pkg::DEV_W-1:0] == dev) &&
                    (tag_q[hlbc_pkg::KEY_W+hlbc_pkg::DEV_W-1:hlbc_pkg::DEV_W] == blk);
  assign ev_better = !found || (ev_dist < pick_dist) ||
                     ((ev_dist == pick_dist) && (ev_time < pick_time));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit <= 1'b0;
      found <= 1'b0;
    end else if (ev_valid) begin
      if (!hit && ev_match) begin
        hit <= 1'b1;
        hit_idx <= ev_idx;
        hit_life <= life_eff;
      end
      if (ev_filled && (ev_ref == '0) && ev_better) begin
        found <= 1'b1;
        pick_idx <= ev_idx;
        pick_dist <= ev_dist;
        pick_time <= ev_time;
      end
    end
  end

  // The next unused slot keeps its release time when it is first filled.
  always_ff @(posedge clk) begin
    if (ev_valid && (CW'(ev_idx) == fill_count)) fill_time <= ev_time;
  end

  // Commit: state writes and the result.
  always_comb begin
    tag_we = 1'b0;
    tag_waddr = pick_idx;
    tag_wdata = {home, blk, dev};
    life_we = 1'b0;
    life_waddr = slot_addr;
    life_wdata = life_eff;
    res_slot = '0;
    res_need = 1'b0;
    res_status = hlbc_pkg::ST_OK;
    fill_next = fill_count;
    if (kind == hlbc_pkg::KIND_GET) begin
      if (hit) begin
        life_we = 1'b1;
        life_waddr = hit_idx;
        life_wdata = {hit_life[LIFE_W-1:hlbc_pkg::COUNT_W],
                      hlbc_pkg::count_inc(hit_life[hlbc_pkg::COUNT_W-1:0])};
        res_slot = hlbc_pkg::SLOT_W'(hit_idx);
      end else if (fill_count < FULL) begin
        tag_we = 1'b1;
        tag_waddr = AW'(fill_count);
        life_we = 1'b1;
        life_waddr = AW'(fill_count);
        life_wdata = {fill_time, 8'd1};
        res_slot = hlbc_pkg::SLOT_W'(fill_count);
        res_need = 1'b1;
        fill_next = fill_count + CW'(1);
      end else if (found) begin
        tag_we = 1'b1;
        life_we = 1'b1;
        life_waddr = pick_idx;
        life_wdata = {pick_time, 8'd1};
        res_slot = hlbc_pkg::SLOT_W'(pick_idx);
        res_need = 1'b1;
      end else begin
        res_status = hlbc_pkg::ST_NO_FREE;
      end
    end else if (slot_in_range) begin
      if (kind == hlbc_pkg::KIND_PIN) begin
        life_we = 1'b1;
        life_wdata = {life_eff[LIFE_W-1:hlbc_pkg::COUNT_W],
                      hlbc_pkg::count_inc(life_eff[hlbc_pkg::COUNT_W-1:0])};
      end else if (life_eff[hlbc_pkg::COUNT_W-1:0] == '0) begin
        res_status = hlbc_pkg::ST_UNDERFLOW;
      end else begin
        life_we = 1'b1;
        life_wdata = {life_eff[LIFE_W-1:hlbc_pkg::COUNT_W],
                      life_eff[hlbc_pkg::COUNT_W-1:0] - 8'd1};
        // The last release stamps the time.
        if ((kind == hlbc_pkg::KIND_RELEASE) && (life_eff[hlbc_pkg::COUNT_W-1:0] == 8'd1)) begin
          life_wdata = {now_tick, 8'd0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      life_vld <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        fill_count <= fill_next;
        if (life_we) life_vld[life_waddr] <= 1'b1;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_data <= {res_status, res_need, res_slot};
  end

  assign m_tvalid = out_valid;
  assign m_tdata = out_data;

  hlbc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES), .AW(AW)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.commit && tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (cmd.scan),
    .raddr (scan_cnt),
    .rdata (tag_q)
  );

  hlbc_ram #(.WIDTH(LIFE_W), .DEPTH(ENTRIES), .AW(AW)) u_life_ram (
    .clk   (clk),
    .we    (cmd.commit && life_we),
    .waddr (life_waddr),
    .wdata (life_wdata),
    .re    (life_re),
    .raddr (life_raddr),
    .rdata (life_q)
  );

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill_count <= FULL)
    else $error("fill count beyond entry count");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || m_tready))
    else $error("result register overwritten while stalled");
  a_fill_only_commit: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(fill_count))
    else $error("fill count changed outside commit");
  a_home_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> ({1'b0, home} < NBUCK))
    else $error("home bucket out of range");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
module tb_top;

  localparam int NUM_SLOTS = 32;
  localparam int HASH_BUCKETS = 13;
  localparam int RANDOM_ITEMS = 400;
  localparam int SLOT_W = hlbc_pkg::SLOT_W;
  localparam int DEV_W = hlbc_pkg::DEV_W;
  localparam int KEY_W = hlbc_pkg::KEY_W;
  localparam int TIME_W = hlbc_pkg::TIME_W;
  localparam int COUNT_W = hlbc_pkg::COUNT_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = hlbc_pkg::COUNT_MAX;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0] s_tuser = hlbc_pkg::KIND_GET;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;

  hashed_lru_block_buffer_cache_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    hlbc_pkg::status_t status;
    logic need_read;
    logic [SLOT_W-1:0] slot;
  } grant_t;

  typedef struct {
    hlbc_pkg::kind_t kind;
    logic [DEV_W-1:0] dev;
    logic [KEY_W-1:0] blk;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] tick;
    bit typed;
    grant_t want;
  } request_t;

  // Shadow copy of the tag store.
  logic [DEV_W-1:0] shadow_dev [NUM_SLOTS];
  logic [KEY_W-1:0] shadow_blk [NUM_SLOTS];
  logic [COUNT_W-1:0] shadow_cnt [NUM_SLOTS];
  logic [TIME_W-1:0] shadow_time [NUM_SLOTS];
  int shadow_fill;

  grant_t pending_grants[$];
  int errors = 0;
  int grants_seen = 0;
  int gets_sent = 0;
  int evictions = 0;
  int no_free_seen = 0;
  int underflows = 0;

  // Recent tags, to steer random gets toward hits.
  logic [DEV_W-1:0] recent_dev [$];
  logic [KEY_W-1:0] recent_blk [$];

  function automatic int bucket_of(logic [DEV_W-1:0] d, logic [KEY_W-1:0] b);
    logic [31:0] h;
    h = 32'(d) * 32'd31 + b;
    return int'(h % HASH_BUCKETS);
  endfunction

  function automatic grant_t predict_grant(request_t r);
    grant_t g;
    int pick;
    bit found;
    int home;
    int b;
    g = '{slot: '0, need_read: 1'b0, status: hlbc_pkg::ST_OK};
    if (r.kind == hlbc_pkg::KIND_GET) begin
      for (int j = 0; j < shadow_fill; j++) begin
        if (shadow_dev[j] == r.dev && shadow_blk[j] == r.blk) begin
          if (shadow_cnt[j] != COUNT_MAX) shadow_cnt[j]++;
          g.slot = SLOT_W'(j);
          return g;
        end
      end
      found = 1'b0;
      pick = 0;
      if (shadow_fill < NUM_SLOTS) begin
        pick = shadow_fill;
        shadow_fill++;
        found = 1'b1;
      end else begin
        home = bucket_of(r.dev, r.blk);
        for (int i = 0; i < HASH_BUCKETS && !found; i++) begin
          b = (home + i) % HASH_BUCKETS;
          for (int j = 0; j < NUM_SLOTS; j++) begin
            if (shadow_cnt[j] == 0 && bucket_of(shadow_dev[j], shadow_blk[j]) == b &&
                (!found || shadow_time[j] < shadow_time[pick])) begin
              pick = j;
              found = 1'b1;
            end
          end
        end
        if (found) evictions++;
      end
      if (found) begin
        shadow_dev[pick] = r.dev;
        shadow_blk[pick] = r.blk;
        shadow_cnt[pick] = 1;
        g.slot = SLOT_W'(pick);
        g.need_read = 1'b1;
      end else begin
        g.status = hlbc_pkg::ST_NO_FREE;
        no_free_seen++;
      end
    end else if (r.slot < NUM_SLOTS) begin
      if (r.kind == hlbc_pkg::KIND_PIN) begin
        if (shadow_cnt[r.slot] != COUNT_MAX) shadow_cnt[r.slot]++;
      end else if (shadow_cnt[r.slot] == 0) begin
        g.status = hlbc_pkg::ST_UNDERFLOW;
        underflows++;
      end else begin
        shadow_cnt[r.slot]--;
        if (r.kind == hlbc_pkg::KIND_RELEASE && shadow_cnt[r.slot] == 0)
          shadow_time[r.slot] = r.tick;
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d want %0d", grants_seen, what, got, want);
    errors++;
  endtask

  // Sender: bursts with random gaps; the predictor runs at acceptance time.
  task automatic send_request(request_t r);
    grant_t g;
    s_tvalid <= 1'b1;
    s_tuser <= r.kind;
    s_tdata <= {3'b0, r.tick, r.slot, r.blk, r.dev};
    do @(posedge clk); while (!s_tready);
    g = predict_grant(r);
    if (r.typed) begin
      if (g != r.want) report_mismatch("directed row", int'(g), int'(r.want));
      g = r.want;
    end
    pending_grants.push_back(g);
    if (r.kind == hlbc_pkg::KIND_GET) begin
      gets_sent++;
      recent_dev.push_back(r.dev);
      recent_blk.push_back(r.blk);
      if (recent_dev.size() > 48) begin
        void'(recent_dev.pop_front());
        void'(recent_blk.pop_front());
      end
    end
  endtask

  int burst_left = 0;

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  function automatic request_t make_request(hlbc_pkg::kind_t k, logic [DEV_W-1:0] d,
                                            logic [KEY_W-1:0] b, logic [SLOT_W-1:0] s,
                                            logic [TIME_W-1:0] t);
    request_t r;
    r = '{kind: k, dev: d, blk: b, slot: s, tick: t, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int sel;
    int idx;
    r = make_request(hlbc_pkg::kind_t'($urandom_range(0, 3)), DEV_W'($urandom),
                     $urandom, SLOT_W'($urandom), $urandom);
    sel = $urandom_range(0, 99);
    if (r.kind == hlbc_pkg::KIND_GET) begin
      if (sel < 45 && recent_dev.size() > 0) begin
        idx = $urandom_range(0, recent_dev.size() - 1);
        r.dev = recent_dev[idx];
        r.blk = recent_blk[idx];
      end else if (sel < 75) begin
        r.dev = DEV_W'($urandom_range(0, 3));
        r.blk = $urandom_range(0, 200);
      end
    end else if (r.kind == hlbc_pkg::KIND_RELEASE && sel < 60) begin
      // Small ticks make equal release times, so ties get exercised.
      r.tick = $urandom_range(0, 1000);
    end
    return r;
  endfunction

  // Receiver: stalls on a repeating pattern mixed with random stretches.
  int rx_phase = 0;

  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = grant_t'(m_tdata);
        grants_seen++;
        if (pending_grants.size() == 0) begin
          report_mismatch("unexpected result", int'(m_tdata), -1);
        end else begin
          want = pending_grants.pop_front();
          if (got.slot != want.slot) report_mismatch("granted_slot", got.slot, want.slot);
          if (got.need_read != want.need_read)
            report_mismatch("need_read", got.need_read, want.need_read);
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
        end
      end
      rx_phase <= (rx_phase + 1) % 600;
      if (rx_phase < 200) m_tready <= 1'b1;
      else if (rx_phase < 400) m_tready <= ((rx_phase % 7) < 3);
      else m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  request_t directed_rows[$];

  initial begin
    request_t r;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      shadow_cnt[i] = '0;
      shadow_time[i] = '0;
    end
    shadow_fill = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Release and unpin of a fresh slot underflow.
    r = make_request(hlbc_pkg::KIND_RELEASE, '0, '0, 5'd0, 32'd7);
    r.typed = 1'b1; r.want = '{slot: '0, need_read: 1'b0, status: hlbc_pkg::ST_UNDERFLOW};
    directed_rows.push_back(r);
    r = make_request(hlbc_pkg::KIND_UNPIN, 8'hff, 32'hffff_ffff, 5'd31, 32'hffff_ffff);
    r.typed = 1'b1; r.want = '{slot: '0, need_read: 1'b0, status: hlbc_pkg::ST_UNDERFLOW};
    directed_rows.push_back(r);
    r = make_request(hlbc_pkg::KIND_GET, 8'd0, 32'd0, 5'd0, 32'd0);
    r.typed = 1'b1; r.want = '{slot: 5'd0, need_read: 1'b1, status: hlbc_pkg::ST_OK};
    directed_rows.push_back(r);
    r = make_request(hlbc_pkg::KIND_GET, 8'hff, 32'hffff_ffff, 5'd31, 32'd0);
    r.typed = 1'b1; r.want = '{slot: 5'd1, need_read: 1'b1, status: hlbc_pkg::ST_OK};
    directed_rows.push_back(r);
    // Hit on slot 0.
    r = make_request(hlbc_pkg::KIND_GET, 8'd0, 32'd0, 5'd0, 32'd0);
    r.typed = 1'b1; r.want = '{slot: 5'd0, need_read: 1'b0, status: hlbc_pkg::ST_OK};
    directed_rows.push_back(r);
    directed_rows.push_back(make_request(hlbc_pkg::KIND_PIN, '0, '0, 5'd1, '0));
    directed_rows.push_back(make_request(hlbc_pkg::KIND_UNPIN, '0, '0, 5'd1, '0));
    directed_rows.push_back(make_request(hlbc_pkg::KIND_RELEASE, '0, '0, 5'd0, 32'hffff_ffff));
    directed_rows.push_back(make_request(hlbc_pkg::KIND_RELEASE, '0, '0, 5'd0, 32'd3));
    directed_rows.push_back(make_request(hlbc_pkg::KIND_RELEASE, '0, '0, 5'd1, 32'd0));
    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Saturate slot 2 after filling it, then walk it back down.
    send_request(make_request(hlbc_pkg::KIND_GET, 8'd1, 32'd77, '0, '0));
    for (int i = 0; i < 260; i++)
      send_request(make_request(hlbc_pkg::KIND_PIN, '0, '0, 5'd2, '0));
    for (int i = 0; i < 256; i++)
      send_request(make_request(hlbc_pkg::KIND_UNPIN, '0, '0, 5'd2, '0));
    send_request(make_request(hlbc_pkg::KIND_RELEASE, '0, '0, 5'd2, 32'd1));

    // Fill every slot and keep it referenced so the next miss finds nothing free.
    for (int i = 3; i < NUM_SLOTS; i++)
      send_request(make_request(hlbc_pkg::KIND_GET, 8'd9, 32'(i * 1000), '0, '0));
    for (int i = 0; i < NUM_SLOTS; i++)
      send_request(make_request(hlbc_pkg::KIND_PIN, '0, '0, SLOT_W'(i), '0));
    send_request(make_request(hlbc_pkg::KIND_GET, 8'h55, 32'h1234_5678, '0, '0));
    for (int i = 0; i < NUM_SLOTS; i++)
      send_request(make_request(hlbc_pkg::KIND_UNPIN, '0, '0, SLOT_W'(i), '0));

    // Hold off until the block has drained.
    s_tvalid <= 1'b0;
    wait (pending_grants.size() == 0);
    @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_request(random_request());
      pace_sender();
    end
    s_tvalid <= 1'b0;

    wait (pending_grants.size() == 0);
    repeat (100) @(posedge clk);
    $display("%0d results checked: %0d gets, %0d evictions, %0d no-free, %0d underflows",
             grants_seen, gets_sent, evictions, no_free_seen, underflows);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- hashed_lru_block_buffer_cache_unit.f -----
sv/hlbc_pkg.sv
sv/hlbc_ram.sv
sv/hlbc_ctrl.sv
sv/hlbc_dp.sv
sv/hashed_lru_block_buffer_cache_unit.sv
sim/tb_top.sv
